// ----- src/kpi_pkg.sv -----
package kpi_pkg;

   localparam int TIME_W  = 32;
   localparam int POS_W   = 48;
   localparam int ANG_W   = 32;
   localparam int FRAC_W  = 16;

   localparam int MAX_POINTS = 128;

   localparam logic [1:0] ST_WRITE   = 2'd0;
   localparam logic [1:0] ST_INTERP  = 2'd1;
   localparam logic [1:0] ST_FIRST   = 2'd2;
   localparam logic [1:0] ST_HELD    = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [6:0]       index;
      logic [31:0]      key_time;
      logic signed [47:0] key_x;
      logic signed [47:0] key_y;
      logic signed [47:0] key_z;
      logic signed [31:0] key_heading;
      logic signed [31:0] key_pitch;
      logic [31:0]      query_time;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       segment;
      logic signed [47:0] out_x;
      logic signed [47:0] out_y;
      logic signed [47:0] out_z;
      logic signed [31:0] out_heading;
      logic signed [31:0] out_pitch;
   } rsp_type;

endpackage

// ----- src/kpi_if.sv -----
interface kpi_req_if;
   import kpi_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface kpi_rsp_if;
   import kpi_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface kpi_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/keyframe_pose_interpolator.sv -----
// Keyframe pose interpolator. A write transaction (cmd 0) stores one keyframe and answers
// with status 0 in the cycle after it is accepted. A query transaction (cmd 1) scans the
// keyframe memory for the first time above query_time, one entry at a time through its
// single read port, then runs one restoring division for the Q0.16 blend factor and blends
// the five pose components through one shared 49x17 multiplier, two products per
// component, in the states S_MULH, S_MULL and S_ACC. A query that takes the first keyframe
// or runs past the end skips the division and the blend. The block accepts one
// transaction at a time; the result waits in the response register.
module keyframe_pose_interpolator (
   input logic clock,
   input logic reset,
   kpi_req_if.sink   req,
   kpi_rsp_if.source rsp,
   kpi_csr_if.sink   csr
);
   import kpi_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int EW = TIME_W + 3 * POS_W + 2 * ANG_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_PREV  = 4'd3;
   localparam logic [3:0] S_PWAIT = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_MULH  = 4'd6;
   localparam logic [3:0] S_MULL  = 4'd7;
   localparam logic [3:0] S_ACC   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [EW-1:0] mem [MAX_POINTS];
   logic [EW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   logic [3:0]   state_ff, state_in;
   logic [7:0]   count_ff;
   logic [CW-1:0] lim_ff, lim_in;
   logic [CW-1:0] i_ff, i_in;
   logic [31:0]  q_ff, q_in;
   logic [EW-1:0] e1_ff, e1_in, e0_ff, e0_in;
   logic [32:0]  rem_ff, rem_in;
   logic [31:0]  den_ff, den_in;
   logic [15:0]  quo_ff, quo_in;
   logic [4:0]   dcnt_ff, dcnt_in;
   logic [2:0]   comp_ff, comp_in;
   logic signed [48:0] diff_ff, diff_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [47:0] hp_ff [3], hp_in [3];
   logic signed [31:0] ha_ff [2], ha_in [2];
   logic         rv_ff, rv_in;
   rsp_type      rd_rsp_ff, rd_rsp_in;

   logic signed [47:0] a_v, b_v;
   logic signed [48:0] mul_a;
   logic [16:0]  mul_b;
   logic signed [65:0] prod;
   logic [32:0]  trial;
   logic [31:0]  e1_time;

   assign wr_en = req.valid && req.ready && req.data.cmd == CMD_WRITE
                  && {1'b0, req.data.index} < (8)'(MAX_POINTS);

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[req.data.index[AW-1:0]] <= {req.data.key_time, req.data.key_x,
            req.data.key_y, req.data.key_z, req.data.key_heading, req.data.key_pitch};
      rd_ff <= mem[rd_addr];
   end

   assign rd_addr = i_ff[AW-1:0];
   assign e1_time = e1_ff[EW-1 -: 32];

   always_comb begin
      case (comp_ff)
         3'd0: begin a_v = e0_ff[207:160]; b_v = e1_ff[207:160]; end
         3'd1: begin a_v = e0_ff[159:112]; b_v = e1_ff[159:112]; end
         3'd2: begin a_v = e0_ff[111:64]; b_v = e1_ff[111:64]; end
         3'd3: begin
            a_v = 48'(signed'(e0_ff[63:32])); b_v = 48'(signed'(e1_ff[63:32]));
         end
         default: begin
            a_v = 48'(signed'(e0_ff[31:0])); b_v = 48'(signed'(e1_ff[31:0]));
         end
      endcase
   end

   always_comb begin
      trial = {rem_ff[31:0], 1'b0} - {1'b0, den_ff};
      mul_a = (state_ff == S_MULL) ? (diff_ff >>> 16) : signed'({33'd0, diff_ff[15:0]});
      mul_b = {1'b0, quo_ff};
      prod = mul_a * signed'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      lim_in = lim_ff; i_in = i_ff; q_in = q_ff;
      e1_in = e1_ff; e0_in = e0_ff; rem_in = rem_ff; den_in = den_ff;
      quo_in = quo_ff; dcnt_in = dcnt_ff; comp_in = comp_ff;
      diff_in = diff_ff; acc_in = acc_ff;
      hp_in = hp_ff; ha_in = ha_ff;
      rv_in = rv_ff; rd_rsp_in = rd_rsp_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !rv_ff) begin
               if (req.data.cmd == CMD_WRITE) begin
                  rd_rsp_in = '0;
                  rd_rsp_in.status = ST_WRITE;
                  rv_in = 1'b1;
               end else begin
                  q_in = req.data.query_time;
                  lim_in = ({1'b0, count_ff} > (9)'(MAX_POINTS)) ? CW'(MAX_POINTS)
                           : CW'(count_ff);
                  i_in = '0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (i_ff >= lim_ff) begin
               rd_rsp_in.status = ST_HELD;
               rd_rsp_in.segment = 8'd128;
               state_in = S_OUT;
            end else state_in = S_CMP;
         end
         S_CMP: begin
            if (rd_ff[EW-1 -: 32] > q_ff) begin
               e1_in = rd_ff;
               rd_rsp_in.segment = 8'(i_ff);
               if (i_ff == '0) begin
                  hp_in[0] = rd_ff[207:160]; hp_in[1] = rd_ff[159:112];
                  hp_in[2] = rd_ff[111:64];
                  ha_in[0] = rd_ff[63:32]; ha_in[1] = rd_ff[31:0];
                  rd_rsp_in.status = ST_FIRST;
                  state_in = S_OUT;
               end else begin
                  i_in = i_ff - 1'b1;
                  state_in = S_PREV;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_PREV: state_in = S_PWAIT;
         S_PWAIT: begin
            e0_in = rd_ff;
            rem_in = {1'b0, q_ff - rd_ff[EW-1 -: 32]};
            den_in = e1_time - rd_ff[EW-1 -: 32];
            quo_in = '0;
            dcnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // numerator (q-t0)<<16, remainder < den so quotient fits 16 bits
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], 1'b0};
               quo_in = {quo_ff[14:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'd15) begin
               comp_in = '0;
               state_in = S_MULH;
            end
         end
         S_MULH: begin
            if (den_ff == '0) quo_in = '0;
            diff_in = 49'(b_v) - 49'(a_v);
            state_in = S_MULL;
         end
         S_MULL: begin
            acc_in = 50'(a_v) + 50'(prod);
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + 50'(prod >>> 16);
            if (comp_ff < 3'd3) hp_in[comp_ff[1:0]] = acc_in[47:0];
            else ha_in[~comp_ff[0]] = acc_in[31:0];
            if (comp_ff == 3'd4) begin
               rd_rsp_in.status = ST_INTERP;
               state_in = S_OUT;
            end else begin
               comp_in = comp_ff + 1'b1;
               state_in = S_MULH;
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rd_rsp_in.out_x = hp_ff[0]; rd_rsp_in.out_y = hp_ff[1];
               rd_rsp_in.out_z = hp_ff[2];
               rd_rsp_in.out_heading = ha_ff[0]; rd_rsp_in.out_pitch = ha_ff[1];
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff <= 1'b0;
         hp_ff <= '{default: '0};
         ha_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         if (csr.valid) count_ff <= csr.data;
         rv_ff <= rv_in;
         hp_ff <= hp_in;
         ha_ff <= ha_in;
      end
      lim_ff <= lim_in; i_ff <= i_in; q_ff <= q_in;
      e1_ff <= e1_in; e0_ff <= e0_in; rem_ff <= rem_in; den_ff <= den_in;
      quo_ff <= quo_in; dcnt_ff <= dcnt_in; comp_ff <= comp_in;
      diff_ff <= diff_in; acc_ff <= acc_in;
      rd_rsp_ff <= rd_rsp_in;
   end

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_rsp_ff;

endmodule

// ----- tb/tb_keyframe_pose_interpolator.sv -----
`timescale 1ns / 100ps

module tb_keyframe_pose_interpolator;
   import kpi_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kpi_req_if req ();
   kpi_rsp_if rsp ();
   kpi_csr_if csr ();

   keyframe_pose_interpolator DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0]        key_times [128];
   logic signed [47:0] key_px [128];
   logic signed [47:0] key_py [128];
   logic signed [47:0] key_pz [128];
   logic signed [31:0] key_hd [128];
   logic signed [31:0] key_pt [128];
   logic signed [47:0] held_x, held_y, held_z;
   logic signed [31:0] held_hd, held_pt;
   int                 active_points;

   rsp_type pose_queue [$];
   int      error_count = 0;
   int      stall_hold = 0;
   bit      stall_random = 1'b1;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic signed [63:0] blend_value(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic [15:0] f);
      logic signed [63:0] diff;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      diff = b - a;
      hi = diff >>> 16;
      lo = diff & 64'hFFFF;
      return a + hi * $signed({48'd0, f}) + ((lo * $signed({48'd0, f})) >>> 16);
   endfunction

   function automatic rsp_type predict_pose(input req_type item);
      rsp_type r;
      int seg;
      int prev;
      logic [63:0] num, den, quo;
      logic [15:0] f;
      r = '0;
      if (item.cmd == CMD_WRITE) begin
         key_times[item.index] = item.key_time;
         key_px[item.index] = item.key_x;
         key_py[item.index] = item.key_y;
         key_pz[item.index] = item.key_z;
         key_hd[item.index] = item.key_heading;
         key_pt[item.index] = item.key_pitch;
         r.status = ST_WRITE;
         return r;
      end
      seg = 128;
      for (int i = 0; i < (active_points > 128 ? 128 : active_points); i++) begin
         if (key_times[i] > item.query_time) begin
            seg = i;
            break;
         end
      end
      if (seg == 128) begin
         r.status = ST_HELD;
      end else if (seg == 0) begin
         held_x = key_px[0];
         held_y = key_py[0];
         held_z = key_pz[0];
         held_hd = key_hd[0];
         held_pt = key_pt[0];
         r.status = ST_FIRST;
      end else begin
         prev = seg - 1;
         num = {32'd0, 32'(item.query_time - key_times[prev])} << 16;
         den = {32'd0, 32'(key_times[seg] - key_times[prev])};
         f = 16'd0;
         if (den != 0) begin
            quo = num / den;
            f = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
         end
         held_x = 48'(blend_value(key_px[prev], key_px[seg], f));
         held_y = 48'(blend_value(key_py[prev], key_py[seg], f));
         held_z = 48'(blend_value(key_pz[prev], key_pz[seg], f));
         held_hd = 32'(blend_value(key_hd[prev], key_hd[seg], f));
         held_pt = 32'(blend_value(key_pt[prev], key_pt[seg], f));
         r.status = ST_INTERP;
      end
      r.segment = 8'(seg);
      r.out_x = held_x;
      r.out_y = held_y;
      r.out_z = held_z;
      r.out_heading = held_hd;
      r.out_pitch = held_pt;
      return r;
   endfunction

   task automatic send_transaction(input req_type item);
      req.valid <= 1'b1;
      req.data <= item;
      do @(posedge clock); while (!req.ready);
      pose_queue.push_back(predict_pose(item));
      if ($urandom_range(3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_point_count(input int n);
      drain();
      csr.valid <= 1'b1;
      csr.data <= 8'(n);
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      active_points = n;
   endtask

   function automatic req_type make_key(input int idx, input logic [31:0] t);
      req_type k;
      k = '0;
      k.cmd = CMD_WRITE;
      k.index = 7'(idx);
      k.key_time = t;
      k.key_x = 48'({$urandom, $urandom});
      k.key_y = 48'({$urandom, $urandom});
      k.key_z = 48'({$urandom, $urandom});
      k.key_heading = $urandom;
      k.key_pitch = $urandom;
      k.query_time = $urandom;
      return k;
   endfunction

   function automatic req_type make_query(input logic [31:0] q);
      req_type k;
      k = '0;
      k.cmd = CMD_QUERY;
      k.index = 7'($urandom);
      k.query_time = q;
      return k;
   endfunction

   // query times mostly near written entries, sometimes fully random
   function automatic logic [31:0] pick_time();
      int n;
      n = active_points > 128 ? 128 : active_points;
      if (n == 0 || $urandom_range(9) == 0) return $urandom;
      return key_times[$urandom_range(n - 1)] + 32'($urandom_range(4)) - 32'd2;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pose_queue.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp.data.status), 64'd0);
         end else begin
            rsp_type want;
            want = pose_queue.pop_front();
            if (rsp.data.status !== want.status)
               report_mismatch("status", 64'(rsp.data.status), 64'(want.status));
            if (rsp.data.segment !== want.segment)
               report_mismatch("segment", 64'(rsp.data.segment), 64'(want.segment));
            if (rsp.data.out_x !== want.out_x)
               report_mismatch("out_x", 64'(rsp.data.out_x), 64'(want.out_x));
            if (rsp.data.out_y !== want.out_y)
               report_mismatch("out_y", 64'(rsp.data.out_y), 64'(want.out_y));
            if (rsp.data.out_z !== want.out_z)
               report_mismatch("out_z", 64'(rsp.data.out_z), 64'(want.out_z));
            if (rsp.data.out_heading !== want.out_heading)
               report_mismatch("out_heading", 64'(rsp.data.out_heading),
                               64'(want.out_heading));
            if (rsp.data.out_pitch !== want.out_pitch)
               report_mismatch("out_pitch", 64'(rsp.data.out_pitch),
                               64'(want.out_pitch));
         end
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp.ready <= 1'b0;
      end else if (stall_random) begin
         rsp.ready <= ($urandom_range(7) > 2);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic fill_table(input int n);
      logic [31:0] t;
      t = $urandom_range(1000);
      for (int i = 0; i < n; i++) begin
         send_transaction(make_key(i, t));
         t = t + 32'($urandom_range(3) == 0 ? 0 : $urandom_range(100000));
      end
   endtask

   task automatic test_empty_table();
      send_transaction(make_query(32'd0));
      send_transaction(make_query(32'hFFFF_FFFF));
   endtask

   task automatic test_directed();
      req_type k;
      // extreme field values
      k = make_key(0, 32'd100);
      k.key_x = 48'h7FFF_FFFF_FFFF; k.key_y = 48'h8000_0000_0000; k.key_z = '0;
      k.key_heading = 32'h7FFF_FFFF; k.key_pitch = 32'h8000_0000;
      send_transaction(k);
      k = make_key(1, 32'hFFFF_FFFF);
      k.key_x = 48'h8000_0000_0000; k.key_y = 48'h7FFF_FFFF_FFFF; k.key_z = '1;
      k.key_heading = 32'h8000_0000; k.key_pitch = 32'h7FFF_FFFF;
      send_transaction(k);
      k = make_key(2, 32'hFFFF_FFFF);
      send_transaction(k);
      k = make_key(127, 32'h0);
      send_transaction(k);
      write_point_count(3);
      send_transaction(make_query(32'd0));
      send_transaction(make_query(32'd99));
      send_transaction(make_query(32'd100));
      send_transaction(make_query(32'h8000_0000));
      send_transaction(make_query(32'hFFFF_FFFE));
      send_transaction(make_query(32'hFFFF_FFFF));
      // unordered times
      k = make_key(1, 32'd50);
      send_transaction(k);
      send_transaction(make_query(32'd60));
      send_transaction(make_query(32'd200));
      write_point_count(1);
      send_transaction(make_query(32'd99));
      send_transaction(make_query(32'd100));
   endtask

   task automatic test_random(input int count, input int n);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(4) == 0)
            send_transaction(make_key($urandom_range(n > 0 ? n - 1 : 0), $urandom));
         else
            send_transaction(make_query(pick_time()));
      end
   endtask

   task automatic test_backpressure();
      stall_hold = 300;
      for (int i = 0; i < 8; i++) send_transaction(make_query(pick_time()));
      drain();
      for (int i = 0; i < 10; i++) send_transaction(make_query(pick_time()));
   endtask

   initial begin
      active_points = 0;
      held_x = '0; held_y = '0; held_z = '0; held_hd = '0; held_pt = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed();
      write_point_count(128);
      fill_table(128);
      test_random(60, 128);
      test_backpressure();
      write_point_count(200);
      test_random(40, 128);
      write_point_count(0);
      test_random(15, 1);
      write_point_count(8);
      fill_table(8);
      stall_random = 1'b0;
      test_random(120, 8);
      stall_random = 1'b1;
      write_point_count(2);
      test_random(60, 2);
      write_point_count(20);
      fill_table(20);
      test_random(70, 20);
      drain();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS keyframe_pose_interpolator");
      end else begin
         $display("FAIL keyframe_pose_interpolator");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL keyframe_pose_interpolator");
      $finish;
   end

endmodule

// ----- files.f -----
src/kpi_pkg.sv
src/kpi_if.sv
src/keyframe_pose_interpolator.sv
tb/tb_keyframe_pose_interpolator.sv
